@@ hw/rtl/gyo_pkg.sv @@
package gyo_pkg;

  // Command word from the sequencer to the datapath.
  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       ang_upd;
    logic       cor_init;
    logic       cor_step;
    logic       cor_fin;
    logic       mul_en;
    logic [2:0] mul_op;
    logic       mul_axis;
    logic       publish;
    logic [4:0] cor_idx;
  } gyo_cmd_t;

  // Steps of the scaling of displacement by cos or sin.
  localparam logic [2:0] OP_LO  = 3'd0;
  localparam logic [2:0] OP_HI  = 3'd1;
  localparam logic [2:0] OP_SUM = 3'd2;
  localparam logic [2:0] OP_RND = 3'd3;
  localparam logic [2:0] OP_ACC = 3'd4;

  // Register indexes of the configuration port.
  localparam logic REG_STEP_MS = 1'b0;
  localparam logic REG_LPC     = 1'b1;

  localparam logic [9:0]  STEP_MS_RESET = 10'd1;
  localparam logic [23:0] LPC_RESET     = 24'd13107;

  localparam int MS_PER_S    = 1000;
  localparam int ROUND_HALF  = 500;
  localparam int CORDIC_GAIN = 652032874;
  localparam int ATAN_ENTRIES = 30;

  // ceil(2^40 / 1000): multiplying by it and dropping 40 bits divides any
  // value below 2^32 by 1000 exactly.
  localparam logic [30:0] RECIP_MS = 31'd1099511628;

  // Cycles for the division of the angle increments to settle.
  localparam int DIV_CYCLES = 3;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [29:0] atan_entry(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10680862;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/gyo_ctrl.sv @@
module gyo_ctrl #(
  parameter int DIV_STEPS    = 3,
  parameter int CORDIC_STEPS = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output gyo_pkg::gyo_cmd_t cmd
);
  import gyo_pkg::*;

  localparam int CNT_MAX = (DIV_STEPS > CORDIC_STEPS) ? DIV_STEPS : CORDIC_STEPS;
  localparam int CW      = $clog2(CNT_MAX + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_ANG   = 3'd2;
  localparam logic [2:0] S_CINIT = 3'd3;
  localparam logic [2:0] S_CORD  = 3'd4;
  localparam logic [2:0] S_CFIN  = 3'd5;
  localparam logic [2:0] S_MUL   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          axis, axis_next;
  logic          out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    axis_next      = axis;
    out_valid_next = out_valid;
    cmd            = '0;
    cmd.cor_idx    = 5'(cnt);
    cmd.mul_op     = 3'(cnt);
    cmd.mul_axis   = axis;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CW'(1);
        if (cnt == CW'(DIV_STEPS - 1)) begin
          state_next = S_ANG;
        end
      end
      S_ANG: begin
        cmd.ang_upd = 1'b1;
        state_next  = S_CINIT;
      end
      S_CINIT: begin
        cmd.cor_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_CORD;
      end
      S_CORD: begin
        cmd.cor_step = 1'b1;
        cnt_next     = cnt + CW'(1);
        if (cnt == CW'(CORDIC_STEPS - 1)) begin
          state_next = S_CFIN;
        end
      end
      S_CFIN: begin
        cmd.cor_fin = 1'b1;
        cnt_next    = '0;
        axis_next   = 1'b0;
        state_next  = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        cnt_next   = cnt + CW'(1);
        if (cnt == CW'(OP_ACC)) begin
          cnt_next  = '0;
          axis_next = 1'b1;
          if (axis) begin
            state_next = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.publish    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      axis      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      axis      <= axis_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ hw/rtl/gyo_dp.sv @@
module gyo_dp #(
  parameter int ANGLE_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  gyo_pkg::gyo_cmd_t   cmd,
  input  logic [9:0]          step_ms,
  input  logic [23:0]         length_per_count,
  input  logic signed [15:0]  roll_rate,
  input  logic signed [15:0]  pitch_rate,
  input  logic signed [15:0]  yaw_rate,
  input  logic signed [31:0]  left_count,
  input  logic signed [31:0]  right_count,
  output logic signed [47:0]  pos_x,
  output logic signed [47:0]  pos_y,
  output logic [23:0]         heading,
  output logic signed [31:0]  roll,
  output logic signed [31:0]  pitch
);
  import gyo_pkg::*;

  localparam int AB = ANGLE_BITS;
  localparam int KS = AB - 12;   // scale from rate units to angle units
  localparam int DW = AB + 14;   // quotient width
  localparam int SW = DW + 3;    // angle sum width
  localparam int XW = 34;        // CORDIC datapath width
  localparam logic [AB:0] EIGHTH = (AB + 1)'(1) << (AB - 3);

  // Angle state
  logic signed [31:0] roll_acc, pitch_acc;
  logic [AB-1:0]      yaw_acc;
  logic [31:0]        last_left, last_right;
  logic signed [47:0] x_acc, y_acc;

  // Rounded division by 1000, one lane per gyro axis. The magnitude m of
  // rate times step is split as m = 1000 * qhi + rhi; the increment is then
  // qhi * 2^KS plus the rounded quotient of rhi * 2^KS by 1000. Both
  // quotients come from a multiplication by the reciprocal.
  logic [2:0][15:0]     rate_in;
  logic [24:0]          mag [3];
  logic [15:0]          qhi [3];
  logic [29:0]          nlo [3];
  logic [DW-1:0]        dv [3];
  logic [2:0]           rneg;
  logic signed [26:0]   rprod [3];
  logic [26:0]          rmag [3];
  logic [55:0]          phi [3];
  logic [60:0]          plo [3];
  logic [9:0]           rhi [3];
  logic [29:0]          nlo_in [3];
  logic [DW-1:0]        dv_in [3];
  logic signed [SW-1:0] delta [3];

  assign rate_in = {yaw_rate, pitch_rate, roll_rate};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rprod[j]  = $signed(rate_in[j]) * $signed({1'b0, step_ms});
      rmag[j]   = rprod[j][26] ? 27'(-rprod[j]) : 27'(rprod[j]);
      phi[j]    = mag[j] * RECIP_MS;
      rhi[j]    = 10'(mag[j] - 25'(qhi[j]) * 25'd1000);
      nlo_in[j] = 30'({rhi[j], {KS{1'b0}}}) + 30'(ROUND_HALF);
      plo[j]    = nlo[j] * RECIP_MS;
      dv_in[j]  = DW'({qhi[j], {KS{1'b0}}}) + DW'(plo[j][60:40]);
      delta[j]  = rneg[j] ? -$signed({3'b000, dv[j]}) : $signed({3'b000, dv[j]});
    end
  end

  logic signed [SW-1:0] roll_sum, pitch_sum;
  logic signed [31:0]   roll_sat, pitch_sat;

  always_comb begin
    roll_sum  = SW'(roll_acc) + delta[0];
    pitch_sum = SW'(pitch_acc) + delta[1];
    if ((roll_sum[SW-1:31] == '0) || (roll_sum[SW-1:31] == '1)) begin
      roll_sat = roll_sum[31:0];
    end else begin
      roll_sat = roll_sum[SW-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end
    if ((pitch_sum[SW-1:31] == '0) || (pitch_sum[SW-1:31] == '1)) begin
      pitch_sat = pitch_sum[31:0];
    end else begin
      pitch_sat = pitch_sum[SW-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end
  end

  // Displacement
  logic signed [32:0] sum_lr;
  logic signed [57:0] disp;
  logic [56:0]        ad;
  logic               dneg;
  logic [31:0]        dl, dr;

  assign dl = left_count - last_left;
  assign dr = right_count - last_right;

  // CORDIC
  logic signed [XW-1:0] cx, cy, cz;
  logic [1:0]           quad;
  logic [AB:0]          hq;
  logic [2:0]           qu;
  logic signed [AB+1:0] rz;
  logic signed [XW-1:0] xs, ys, at, co, si;

  always_comb begin
    hq = {1'b0, yaw_acc} + EIGHTH;
    qu = hq[AB:AB-2];
    rz = $signed({2'b00, yaw_acc}) - $signed({1'b0, qu, {(AB - 2){1'b0}}});
    xs = cx >>> cmd.cor_idx;
    ys = cy >>> cmd.cor_idx;
    at = XW'(atan_entry(cmd.cor_idx));
    case (quad)
      2'd0: begin co = cx;  si = cy;  end
      2'd1: begin co = -cy; si = cx;  end
      2'd2: begin co = -cx; si = -cy; end
      default: begin co = cy; si = -cx; end
    endcase
  end

  // Scaling of displacement by cos and sin
  logic [31:0]        ac_x, ac_y, ac_sel;
  logic               nx, ny, nsel;
  logic [60:0]        mp;
  logic [88:0]        pacc;
  logic signed [58:0] rnd;
  logic signed [59:0] psum;
  logic signed [47:0] acc_sel, acc_sat;

  always_comb begin
    ac_sel  = cmd.mul_axis ? ac_y : ac_x;
    nsel    = cmd.mul_axis ? ny : nx;
    acc_sel = cmd.mul_axis ? y_acc : x_acc;
    psum    = 60'(acc_sel) + 60'(rnd);
    if ((psum[59:47] == '0) || (psum[59:47] == '1)) begin
      acc_sat = psum[47:0];
    end else begin
      acc_sat = psum[59] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end
  end

  // Architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      roll_acc   <= '0;
      pitch_acc  <= '0;
      yaw_acc    <= '0;
      last_left  <= '0;
      last_right <= '0;
      x_acc      <= '0;
      y_acc      <= '0;
    end else begin
      if (cmd.load) begin
        last_left  <= left_count;
        last_right <= right_count;
      end
      if (cmd.ang_upd) begin
        roll_acc  <= roll_sat;
        pitch_acc <= pitch_sat;
        yaw_acc   <= yaw_acc + delta[2][AB-1:0];
      end
      if (cmd.mul_en && (cmd.mul_op == OP_ACC)) begin
        if (cmd.mul_axis) begin
          y_acc <= acc_sat;
        end else begin
          x_acc <= acc_sat;
        end
      end
    end
  end

  // Working registers. The division stages settle one after another while
  // the loaded magnitudes stay put, so three steps leave the quotient in dv.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int j = 0; j < 3; j++) begin
        mag[j]  <= rmag[j][24:0];
        rneg[j] <= rprod[j][26];
      end
      sum_lr <= 33'($signed(dl)) + 33'($signed(dr));
    end
    if (cmd.div_step) begin
      for (int j = 0; j < 3; j++) begin
        qhi[j] <= phi[j][55:40];
        nlo[j] <= nlo_in[j];
        dv[j]  <= dv_in[j];
      end
    end
    if (cmd.ang_upd) begin
      disp <= sum_lr * $signed({1'b0, length_per_count});
    end
    if (cmd.cor_init) begin
      ad   <= disp[57] ? 57'(-disp) : 57'(disp);
      dneg <= disp[57];
      quad <= qu[1:0];
      cz   <= XW'(rz) <<< (32 - AB);
      cx   <= XW'(CORDIC_GAIN);
      cy   <= '0;
    end
    if (cmd.cor_step) begin
      if (!cz[XW-1]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - at;
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + at;
      end
    end
    if (cmd.cor_fin) begin
      ac_x <= co[XW-1] ? 32'(-co) : 32'(co);
      ac_y <= si[XW-1] ? 32'(-si) : 32'(si);
      nx   <= dneg ^ co[XW-1];
      ny   <= dneg ^ si[XW-1];
    end
    if (cmd.mul_en) begin
      case (cmd.mul_op)
        OP_LO:  mp <= 61'(ad[28:0] * ac_sel);
        OP_HI: begin
          pacc <= 89'(mp);
          mp   <= 61'(ad[56:29] * ac_sel);
        end
        OP_SUM: pacc <= pacc + (89'(mp) << 29) + (89'(1) << 30);
        OP_RND: rnd <= nsel ? -$signed({1'b0, pacc[88:31]}) : $signed({1'b0, pacc[88:31]});
        default: ;
      endcase
    end
    if (cmd.publish) begin
      pos_x   <= x_acc;
      pos_y   <= y_acc;
      heading <= 24'(yaw_acc);
      roll    <= roll_acc;
      pitch   <= pitch_acc;
    end
  end

endmodule

@@ hw/rtl/gyro_encoder_odometry.sv @@
// Dead-reckoning odometry for a two-wheeled vehicle with a three-axis gyro.
//
// The input channel (in_valid/in_ready) carries one sensor sample per
// transfer: three gyro rates and the two free-running wheel encoder counts.
// The output channel (out_valid/out_ready) returns one pose per sample:
// x and y position, heading, roll and pitch. Configuration (step_ms and
// length_per_count) is written over the APB port; the user must do so
// only while the block is idle, which the block itself does not enforce.
//
// A sample goes through these steps from its transfer to its result: the
// angle increments are divided by 1000 through reciprocal multiplication,
// the angles are updated, the CORDIC is set up, CORDIC_STEPS rotations
// run, the quadrant is folded back, the shared 29 by 32 bit multiplier
// scales the displacement for x and y, and the output register is loaded.
// One sample is processed at a time, so the next sample is taken only
// once the last one has been loaded into the output register.
//
// Reset clears all accumulators and the remembered encoder counts and
// restores the configuration defaults. The result sits in an output
// register; if the receiver stalls, the next sample is still taken and
// worked on, and waits only for that register to empty.
module gyro_encoder_odometry #(
  parameter int CORDIC_STEPS = 20,
  parameter int ANGLE_BITS   = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] roll_rate,
  input  logic signed [15:0] pitch_rate,
  input  logic signed [15:0] yaw_rate,
  input  logic signed [31:0] left_count,
  input  logic signed [31:0] right_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] pos_x,
  output logic signed [47:0] pos_y,
  output logic [23:0]        heading,
  output logic signed [31:0] roll,
  output logic signed [31:0] pitch
);
  import gyo_pkg::*;

  logic [9:0]  step_ms;
  logic [23:0] length_per_count;
  gyo_cmd_t    cmd;

  // The register port never inserts wait states.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ms          <= STEP_MS_RESET;
      length_per_count <= LPC_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_STEP_MS: step_ms          <= pwdata[9:0];
        REG_LPC:     length_per_count <= pwdata[23:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_STEP_MS: prdata = {22'd0, step_ms};
      REG_LPC:     prdata = {8'd0, length_per_count};
    endcase
  end

  // The sequencer steps the datapath through division, angle update,
  // CORDIC rotation and position update.
  gyo_ctrl #(
    .DIV_STEPS    (DIV_CYCLES),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  gyo_dp #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .step_ms          (step_ms),
    .length_per_count (length_per_count),
    .roll_rate        (roll_rate),
    .pitch_rate       (pitch_rate),
    .yaw_rate         (yaw_rate),
    .left_count       (left_count),
    .right_count      (right_count),
    .pos_x            (pos_x),
    .pos_y            (pos_y),
    .heading          (heading),
    .roll             (roll),
    .pitch            (pitch)
  );

endmodule

@@ hw/rtl/gyo_checker.sv @@
module gyo_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [47:0] pos_x,
  input logic [23:0]        heading
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(heading))
    else $error("stalled result changed");

  // Once a sample is taken the block is busy with it.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken while busy");

  // No result can appear in the cycle straight after a sample is taken.
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result without processing time");

endmodule

bind gyro_encoder_odometry gyo_checker u_gyo_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .pos_x     (pos_x),
  .heading   (heading)
);

@@ sim/gyro_encoder_odometry_tb.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the odometry block. Sensor samples are queued by the
// stimulus process and sent by a clocked driver. A clocked monitor takes the
// poses and compares them, field by field, with the poses that a predictor
// worked out when each sample transfer was accepted. The predictor keeps its
// own copy of the integrators, the remembered encoder counts and the two
// configuration registers.
module gyro_encoder_odometry_tb;
  import gyo_pkg::*;

  localparam int CLK_HALF  = 4;
  localparam int LIMIT     = 900000;
  localparam int SETTLE    = 90;      // well over the latency of one sample
  localparam int N_RANDOM  = 1080;
  localparam logic [2:0] ADDR_STEP_MS = {REG_STEP_MS, 2'b00};
  localparam logic [2:0] ADDR_LPC     = {REG_LPC, 2'b00};
  localparam longint POS_TOP = (64'sd1 <<< 47) - 1;
  localparam longint POS_BOT = -(64'sd1 <<< 47);

  // atan(2^-i) in 2^-32 turn, for the first twenty rotations.
  localparam longint ROT_ANGLE [20] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304};

  typedef struct packed {
    logic signed [15:0] roll_r;
    logic signed [15:0] pitch_r;
    logic signed [15:0] yaw_r;
    logic signed [31:0] left_c;
    logic signed [31:0] right_c;
  } sample_t;

  typedef struct packed {
    logic signed [47:0] x;
    logic signed [47:0] y;
    logic [23:0]        hdg;
    logic signed [31:0] roll_a;
    logic signed [31:0] pitch_a;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] roll_rate = '0, pitch_rate = '0, yaw_rate = '0;
  logic signed [31:0] left_count = '0, right_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [47:0] pos_x, pos_y;
  logic [23:0] heading;
  logic signed [31:0] roll, pitch;

  gyro_encoder_odometry uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .roll_rate(roll_rate), .pitch_rate(pitch_rate), .yaw_rate(yaw_rate),
    .left_count(left_count), .right_count(right_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .pos_x(pos_x), .pos_y(pos_y), .heading(heading), .roll(roll), .pitch(pitch)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // Samples still to be sent, and poses still to arrive, oldest first.
  sample_t sample_q[$];
  pose_t   pose_q[$];
  int      open_samples = 0;    // queued but whose pose has not yet arrived
  int      fails = 0;
  int      poses_seen = 0;
  int      settings_used = 0;
  bit      calm = 1'b0;         // no idling on either side in the final stretch
  bit      choke = 1'b0;        // receiver held off for a long stretch

  // Predictor state and its copy of the configuration.
  logic [9:0]  cfg_step = STEP_MS_RESET;
  logic [23:0] cfg_lpc  = LPC_RESET;
  longint      est_x = 0, est_y = 0, est_roll = 0, est_pitch = 0;
  logic [23:0] est_yaw = '0;
  logic [31:0] est_left = '0, est_right = '0;

  // Angle gained over one step, in 2^-24 turn, rounded with ties away from 0.
  function automatic longint turn_gain(input logic signed [15:0] rate);
    longint num, mag, q;
    num = longint'(rate) * longint'(cfg_step) * 4096;
    mag = (num < 0) ? -num : num;
    q = (mag + ROUND_HALF) / MS_PER_S;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp48(input longint v);
    if (v > POS_TOP) return POS_TOP;
    if (v < POS_BOT) return POS_BOT;
    return v;
  endfunction

  // round(d * c / 2^31), ties away from zero, done exactly in wide arithmetic.
  function automatic longint project(input longint d, input longint c);
    logic [127:0] ad, ac, p;
    longint r;
    ad = (d < 0) ? -d : d;
    ac = (c < 0) ? -c : c;
    p = ad * ac + (128'd1 << 30);
    r = longint'(p >> 31);
    return ((d < 0) != (c < 0)) ? -r : r;
  endfunction

  // Q30 cos and sin of a heading: quadrant folding, then twenty rotations.
  task automatic heading_sincos(input logic [23:0] h, output longint co,
                                output longint si);
    longint hv, qu, z, x, y, xs, ys;
    hv = longint'(h);
    qu = (hv + (64'sd1 <<< 21)) >>> 22;
    z = (hv - (qu <<< 22)) * 256;
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < 20; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ROT_ANGLE[i];
      end else begin
        x += ys; y -= xs; z += ROT_ANGLE[i];
      end
    end
    case (qu[1:0])
      2'd0: begin co = x;  si = y;  end
      2'd1: begin co = -y; si = x;  end
      2'd2: begin co = -x; si = -y; end
      default: begin co = y; si = -x; end
    endcase
  endtask

  // Advance the predicted pose by one sample and return it.
  task automatic advance_pose(input sample_t s, output pose_t p);
    logic signed [31:0] dl, dr;
    longint travel, co, si;
    dl = s.left_c - est_left;
    dr = s.right_c - est_right;
    est_roll  = clamp32(est_roll + turn_gain(s.roll_r));
    est_pitch = clamp32(est_pitch + turn_gain(s.pitch_r));
    est_yaw   = est_yaw + 24'(turn_gain(s.yaw_r));
    travel = (longint'(dl) + longint'(dr)) * longint'(cfg_lpc);
    heading_sincos(est_yaw, co, si);
    est_x = clamp48(est_x + project(travel, co));
    est_y = clamp48(est_y + project(travel, si));
    est_left  = s.left_c;
    est_right = s.right_c;
    p.x = est_x[47:0];
    p.y = est_y[47:0];
    p.hdg = est_yaw;
    p.roll_a = est_roll[31:0];
    p.pitch_a = est_pitch[31:0];
  endtask

  // Driver: holds each sample until its transfer, then either idles for a
  // burst or offers the next one. The pose is predicted at the transfer.
  int gap_left = 0;
  always @(posedge clk) begin
    pose_t p;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) begin
        advance_pose({roll_rate, pitch_rate, yaw_rate, left_count, right_count}, p);
        pose_q.push_back(p);
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        {roll_rate, pitch_rate, yaw_rate, left_count, right_count} <= sample_q.pop_front();
        in_valid <= 1'b1;
        if (!calm && $urandom_range(7) == 0) gap_left <= $urandom_range(1, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each pose transfer against the oldest prediction and
  // chooses out_ready for the next cycle.
  int stall_left = 0;
  always @(posedge clk) begin
    pose_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        poses_seen++;
        if (pose_q.size() == 0) begin
          $error("pose arrived with no sample outstanding");
          fails++;
        end else begin
          e = pose_q.pop_front();
          open_samples--;
          if (pos_x !== e.x) begin
            $error("pos_x: expected %0d, got %0d", e.x, pos_x); fails++;
          end
          if (pos_y !== e.y) begin
            $error("pos_y: expected %0d, got %0d", e.y, pos_y); fails++;
          end
          if (heading !== e.hdg) begin
            $error("heading: expected %0d, got %0d", e.hdg, heading); fails++;
          end
          if (roll !== e.roll_a) begin
            $error("roll: expected %0d, got %0d", e.roll_a, roll); fails++;
          end
          if (pitch !== e.pitch_a) begin
            $error("pitch: expected %0d, got %0d", e.pitch_a, pitch); fails++;
          end
        end
      end
      if (choke) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(9) == 0) begin
        stall_left <= $urandom_range(0, 11);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("gyro_encoder_odometry_tb failed");
      $finish;
    end
  end

  task automatic queue_sample(input logic signed [15:0] r, input logic signed [15:0] p,
                              input logic signed [15:0] y, input logic [31:0] l,
                              input logic [31:0] rc);
    sample_q.push_back({r, p, y, l, rc});
    open_samples++;
  endtask

  // A register write over the configuration port: setup, then access.
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic configure(input logic [9:0] step, input logic [23:0] lpc);
    reg_write(ADDR_STEP_MS, {22'd0, step});
    reg_write(ADDR_LPC, {8'd0, lpc});
    cfg_step = step;
    cfg_lpc = lpc;
    settings_used++;
  endtask

  // Wait until every queued sample has come back as a pose, then settle.
  task automatic drain;
    while (open_samples != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  logic [31:0] gen_left = '0, gen_right = '0;

  // Mostly a vehicle in plausible motion: modest rates and small, related
  // encoder steps. The rest is raw noise over the whole field ranges.
  task automatic queue_random;
    logic signed [15:0] r, p, y;
    int base;
    if ($urandom_range(6) == 0) begin
      r = 16'($urandom); p = 16'($urandom); y = 16'($urandom);
      gen_left = $urandom; gen_right = $urandom;
    end else begin
      r = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
      p = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
      y = $signed(16'($urandom_range(0, 16000))) - 16'sd8000;
      base = $urandom_range(0, 400) - 200;
      gen_left  = gen_left + 32'(base + $urandom_range(0, 40) - 20);
      gen_right = gen_right + 32'(base + $urandom_range(0, 40) - 20);
    end
    queue_sample(r, p, y, gen_left, gen_right);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings. The first sample is measured
    // against zero encoder counts; then the counters wrap across the signed
    // boundary and jump by the largest deltas either way, and the rates take
    // their extremes so that the heading wraps in both directions.
    queue_sample(16'sd0, 16'sd0, 16'sd0, 32'd1000, 32'd1000);
    queue_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_sample(16'sh8000, 16'sh7FFF, 16'sh8000, 32'h8000_0000, 32'h8000_0001);
    queue_sample(16'sd1, -16'sd1, 16'sd0, 32'h0000_0000, 32'h7FFF_FFFF);
    queue_sample(16'sd0, 16'sd0, 16'sd4096, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_sample(16'sd0, 16'sd0, 16'sd0, 32'h8000_0000, 32'h8000_0000);
    drain();

    // Largest step and length per count: the roll and pitch integrators
    // clamp, and a run of big encoder steps at a heading that does not change
    // drives the position into its limits.
    configure(10'd1000, 24'hFF_FFFF);
    gen_left = 32'h8000_0000; gen_right = 32'h8000_0000;
    for (int i = 0; i < 18; i++) begin
      gen_left = gen_left + 32'h7FFF_FFFF;
      gen_right = gen_right + 32'h7FFF_FFFF;
      queue_sample(16'sh7FFF, 16'sh8000, 16'sd8192, gen_left, gen_right);
    end
    drain();

    // A step of zero freezes every angle while the wheels still move.
    configure(10'd0, 24'd0);
    queue_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF, 32'd5, 32'd9);
    queue_sample(16'sh8000, 16'sh7FFF, 16'sh8000, 32'hFFFF_0000, 32'h0001_0000);
    drain();

    configure(10'd1023, 24'd1);
    queue_sample(16'sh8000, 16'sh8000, 16'sh8000, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_sample(16'sh8000, 16'sh7FFF, 16'sh7FFF, 32'h7FFF_FFFF, 32'h8000_0000);
    drain();

    // Random phases, each at its own setting. In the first, the receiver is
    // held off for a long stretch so the block fills up and stalls its input.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) configure(10'd1, 24'd13107);
      else configure(10'($urandom_range(1, 1000)), 24'($urandom));
      if (ph == 5) calm = 1'b1;
      for (int i = 0; i < N_RANDOM / 6; i++) queue_random();
      if (ph == 0) begin
        choke = 1'b1;
        repeat (600) @(posedge clk);
        choke = 1'b0;
      end
      drain();
    end

    $display("Sent %0d sensor samples under %0d register settings, with stalls",
             poses_seen, settings_used);
    $display("and idle bursts on both channels, counter wraps and clamping.");
    if (fails == 0) begin
      $display("gyro_encoder_odometry_tb passed");
    end else begin
      $display("gyro_encoder_odometry_tb failed");
    end
    $finish;
  end

endmodule
